// File: design/pid_pkg.sv
// pid_pkg: shared types, constants and helpers for the palette image decoder
// used by pid_ram users, pid_ctrl, pid_datapath and the top level
`timescale 1ns / 1ps
`default_nettype none

package pid_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_ADDR_W    = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int COLOR_W       = 16;
    localparam int ACC_W         = 23;
    localparam int HELD_W        = 5;
    localparam int IDXW_W        = 5;

    // stream parse phase
    typedef enum logic [2:0] {
        PH_CNT_LO = 3'd0,
        PH_CNT_HI = 3'd1,
        PH_ENT_LO = 3'd2,
        PH_ENT_HI = 3'd3,
        PH_PIXELS = 3'd4
    } phase_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_SCAN  = 3'd1,
        ST_FETCH = 3'd2,
        ST_HI    = 3'd3,
        ST_LO    = 3'd4
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic scan;
        logic load_hi;
        logic load_lo;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic have_pixel;
        logic last_pixel;
    } dp_status_t;

    // bit length of (count - 1), with 1 for a count of 1 and 0 for a count of 0
    function automatic logic [IDXW_W-1:0] index_width_of(input logic [15:0] count);
        logic [15:0]       v;
        logic [IDXW_W-1:0] w;
        v = count - 16'd1;
        w = '0;
        for (int i = 0; i < 16; i++) begin
            if (v[i]) begin
                w = IDXW_W'(i + 1);
            end
        end
        if (count == 16'd0) begin
            w = '0;
        end else if (count == 16'd1) begin
            w = IDXW_W'(1);
        end
        return w;
    endfunction

endpackage

`default_nettype wire

// File: design/pid_ram.sv
// pid_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module pid_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                                  aclk,
    input  wire logic                                  wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                      wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

`default_nettype wire

// File: design/pid_ctrl.sv
// pid_ctrl: sequencing state machine for one request at a time
// depends on pid_pkg; drives pid_datapath through dp_cmd_t
`timescale 1ns / 1ps
`default_nettype none

module pid_ctrl
    import pid_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  wire logic       m_ready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (status.have_pixel) begin
                    cmd.scan   = 1'b1;
                    state_next = ST_FETCH;
                end else begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_FETCH: begin
                cmd.load_hi = 1'b1;
                state_next  = ST_HI;
            end
            ST_HI: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    cmd.load_lo = 1'b1;
                    state_next  = ST_LO;
                end
            end
            ST_LO: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (status.last_pixel) begin
                        cmd.finish = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: design/pid_datapath.sv
// pid_datapath: header parse, palette store, index unpacking and output register
// depends on pid_pkg and pid_ram; commanded by pid_ctrl
`timescale 1ns / 1ps
`default_nettype none

module pid_datapath
    import pid_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire dp_cmd_t    cmd,
    output dp_status_t      status,
    input  wire logic [7:0] s_stream_byte,
    input  wire logic       s_end_of_stream,
    output logic [7:0]      m_pixel_byte,
    output logic            m_bad_index,
    output logic            m_run_last
);

    phase_t              phase_reg,    phase_next;
    logic [15:0]         count_reg,    count_next;
    logic [15:0]         loaded_reg,   loaded_next;
    logic [7:0]          held_reg,     held_next;
    logic [IDXW_W-1:0]   width_reg,    width_next;
    logic [ACC_W-1:0]    acc_reg,      acc_next;
    logic [HELD_W-1:0]   bits_reg,     bits_next;
    logic                eos_reg,      eos_next;
    logic                pix_item_reg, pix_item_next;
    logic                bad_reg,      bad_next;
    logic                inrange_reg,  inrange_next;
    logic                last_reg,     last_next;
    logic [COLOR_W-1:0]  color_reg,    color_next;
    logic [7:0]          out_byte_reg, out_byte_next;
    logic                out_bad_reg,  out_bad_next;
    logic                out_last_reg, out_last_next;

    logic [15:0]            mask;
    logic [15:0]            idx;
    logic                   take_full;
    logic [HELD_W-1:0]      bits_after;
    logic                   ram_we;
    logic [PAL_ADDR_W-1:0]  ram_waddr;
    logic [COLOR_W-1:0]     ram_wdata;
    logic [COLOR_W-1:0]     ram_rdata;
    logic [15:0]            loaded_inc;

    pid_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (idx[PAL_ADDR_W-1:0]),
        .rd_data (ram_rdata)
    );

    assign mask       = 16'((17'd1 << width_reg) - 17'd1);
    assign idx        = acc_reg[15:0] & mask;
    assign take_full  = (bits_reg >= HELD_W'(width_reg));
    assign bits_after = take_full ? (bits_reg - HELD_W'(width_reg)) : '0;
    assign loaded_inc = loaded_reg + 16'd1;

    assign ram_we    = cmd.accept && (phase_reg == PH_ENT_HI)
                       && (32'(loaded_reg) < PALETTE_DEPTH);
    assign ram_waddr = loaded_reg[PAL_ADDR_W-1:0];
    assign ram_wdata = {s_stream_byte, held_reg};

    assign status.have_pixel = pix_item_reg && (width_reg != '0)
                               && (take_full || (eos_reg && (bits_reg != '0)));
    assign status.last_pixel = last_reg;

    assign m_pixel_byte = out_byte_reg;
    assign m_bad_index  = out_bad_reg;
    assign m_run_last   = out_last_reg;

    always_comb begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        loaded_next   = loaded_reg;
        held_next     = held_reg;
        width_next    = width_reg;
        acc_next      = acc_reg;
        bits_next     = bits_reg;
        eos_next      = eos_reg;
        pix_item_next = pix_item_reg;
        bad_next      = bad_reg;
        inrange_next  = inrange_reg;
        last_next     = last_reg;
        color_next    = color_reg;
        out_byte_next = out_byte_reg;
        out_bad_next  = out_bad_reg;
        out_last_next = out_last_reg;

        if (cmd.accept) begin
            eos_next      = s_end_of_stream;
            pix_item_next = (phase_reg == PH_PIXELS);
            unique case (phase_reg)
                PH_CNT_LO: begin
                    held_next  = s_stream_byte;
                    phase_next = PH_CNT_HI;
                end
                PH_CNT_HI: begin
                    count_next  = {s_stream_byte, held_reg};
                    loaded_next = '0;
                    acc_next    = '0;
                    bits_next   = '0;
                    if ({s_stream_byte, held_reg} == 16'd0) begin
                        width_next = '0;
                        phase_next = PH_PIXELS;
                    end else begin
                        phase_next = PH_ENT_LO;
                    end
                end
                PH_ENT_LO: begin
                    held_next  = s_stream_byte;
                    phase_next = PH_ENT_HI;
                end
                PH_ENT_HI: begin
                    loaded_next = loaded_inc;
                    if (loaded_inc >= count_reg) begin
                        width_next = index_width_of(count_reg);
                        phase_next = PH_PIXELS;
                    end else begin
                        phase_next = PH_ENT_LO;
                    end
                end
                PH_PIXELS: begin
                    if (width_reg != '0) begin
                        acc_next  = acc_reg | (ACC_W'(s_stream_byte) << bits_reg);
                        bits_next = bits_reg + HELD_W'(8);
                    end
                end
                default: begin
                    phase_next = PH_CNT_LO;
                end
            endcase
            // end of stream returns to the header
            if (s_end_of_stream) begin
                phase_next  = PH_CNT_LO;
                loaded_next = '0;
            end
        end

        if (cmd.scan) begin
            bad_next     = (idx >= count_reg);
            inrange_next = (32'(idx) < PALETTE_DEPTH);
            if (take_full) begin
                acc_next = acc_reg >> width_reg;
            end else begin
                // straddling index at end of stream, zero padded
                acc_next = '0;
            end
            bits_next = bits_after;
            last_next = !((bits_after >= HELD_W'(width_reg))
                          || (eos_reg && (bits_after != '0)));
        end

        if (cmd.load_hi) begin
            color_next    = (inrange_reg && !bad_reg) ? ram_rdata : '0;
            out_byte_next = color_next[15:8];
            out_bad_next  = bad_reg;
            out_last_next = 1'b0;
        end

        if (cmd.load_lo) begin
            out_byte_next = color_reg[7:0];
            out_last_next = last_reg;
        end

        if (cmd.finish && eos_reg) begin
            acc_next  = '0;
            bits_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_CNT_LO;
            count_reg    <= '0;
            loaded_reg   <= '0;
            held_reg     <= '0;
            width_reg    <= '0;
            acc_reg      <= '0;
            bits_reg     <= '0;
            eos_reg      <= 1'b0;
            pix_item_reg <= 1'b0;
            last_reg     <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            loaded_reg   <= loaded_next;
            held_reg     <= held_next;
            width_reg    <= width_next;
            acc_reg      <= acc_next;
            bits_reg     <= bits_next;
            eos_reg      <= eos_next;
            pix_item_reg <= pix_item_next;
            last_reg     <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        bad_reg      <= bad_next;
        inrange_reg  <= inrange_next;
        color_reg    <= color_next;
        out_byte_reg <= out_byte_next;
        out_bad_reg  <= out_bad_next;
        out_last_reg <= out_last_next;
    end

endmodule

`default_nettype wire

// File: design/palette_image_decoder.sv
// palette_image_decoder: top level, joins pid_ctrl and pid_datapath
// depends on pid_pkg, pid_ctrl, pid_datapath (and pid_ram through it)
//
// input channel s_*: one stream byte per request, s_end_of_stream on the
// final byte. the stream is a little-endian 16-bit palette count, that
// many little-endian 16-bit colors, then packed pixel indices, lsb first.
// output channel m_*: decoded colors as byte pairs, high byte first;
// m_bad_index flags an index at or above the count, m_run_last marks the
// last byte produced by one input byte.
// one request is in work at a time: s_ready is high only while idle.
// header bytes and pixel bytes that complete no index pass through
// the accept and scan states. a pixel byte is accepted, then each decoded
// index passes through index select, palette read, high byte and low byte;
// the single read port of the palette ram and the one output register
// keep these steps in sequence.
// a stalled receiver holds the current byte in the output register and
// freezes decoding. reset returns to the palette count phase; palette ram
// contents are not cleared and their read data is only used for entries
// of the current palette.
`timescale 1ns / 1ps
`default_nettype none

module palette_image_decoder
    import pid_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_stream_byte,
    input  wire logic       s_end_of_stream,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_pixel_byte,
    output logic            m_bad_index,
    output logic            m_run_last
);

    dp_cmd_t    cmd;
    dp_status_t status;

    pid_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    pid_datapath u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_stream_byte   (s_stream_byte),
        .s_end_of_stream (s_end_of_stream),
        .m_pixel_byte    (m_pixel_byte),
        .m_bad_index     (m_bad_index),
        .m_run_last      (m_run_last)
    );

endmodule

`default_nettype wire

// File: design/pid_checker.sv
// pid_checker: port-level assertions for palette_image_decoder, bound to the top
// depends only on the top level's ports
`timescale 1ns / 1ps
`default_nettype none

module pid_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_pixel_byte,
    input wire logic       m_bad_index,
    input wire logic       m_run_last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pixel_byte)
            && $stable(m_bad_index) && $stable(m_run_last))
        else $error("result changed while stalled");

    // one request at a time: never taking input while a result is shown
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while result pending");

    // after the last result of a request the block goes idle
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_run_last |=> s_ready && !m_valid)
        else $error("block not idle after last result");

    // an accepted request is still being worked on in the cycle after the accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready && !m_valid)
        else $error("ready or result right after accept");

endmodule

bind palette_image_decoder pid_checker u_pid_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_pixel_byte (m_pixel_byte),
    .m_bad_index  (m_bad_index),
    .m_run_last   (m_run_last)
);

`default_nettype wire

// File: sim/palette_image_decoder_checker.sv
// palette_image_decoder_checker: watches both channels of the palette image decoder,
// predicts each decoded color byte from the accepted stream bytes and compares.
// depends on pid_pkg for the phase encoding and the palette depth
`timescale 1ns / 1ps

module palette_image_decoder_checker
    import pid_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_stream_byte,
    input  logic       s_end_of_stream,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_pixel_byte,
    input  logic       m_bad_index,
    input  logic       m_run_last,
    output int         mismatches,
    output int         outstanding
);

    typedef struct packed {
        logic [7:0] value;
        logic       bad;
        logic       last;
    } pixel_byte_t;

    phase_t            phase;
    logic [15:0]       count;
    logic [15:0]       loaded;
    logic [7:0]        held_lo;
    logic [15:0]       colors [PALETTE_DEPTH];
    logic [IDXW_W-1:0] width;
    logic [31:0]       bit_acc;
    int                nbits;
    pixel_byte_t       pixel_bytes_due[$];
    pixel_byte_t       due;

    task automatic flag_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // index bits needed to address count entries
    function automatic logic [IDXW_W-1:0] bits_for(input logic [15:0] n);
        logic [15:0]       v;
        logic [IDXW_W-1:0] w;
        v = n - 16'd1;
        w = '0;
        if (n == 16'd0) return '0;
        if (n == 16'd1) return IDXW_W'(1);
        while (v != 16'd0) begin
            v = v >> 1;
            w = w + 1'b1;
        end
        return w;
    endfunction

    task automatic emit_pixel(input logic [15:0] idx);
        logic [15:0] color;
        logic        bad;
        color = '0;
        bad = (idx >= count);
        // entries past the store depth were dropped and read as zero
        if (!bad && idx < PALETTE_DEPTH) begin
            color = colors[idx[PAL_ADDR_W-1:0]];
        end
        pixel_bytes_due.push_back(pixel_byte_t'{color[15:8], bad, 1'b0});
        pixel_bytes_due.push_back(pixel_byte_t'{color[7:0], bad, 1'b0});
    endtask

    task automatic decode_stream_byte(input logic [7:0] b, input logic eos);
        logic [31:0] mask;
        int          produced;
        produced = 0;
        case (phase)
            PH_CNT_LO: begin
                held_lo = b;
                phase = PH_CNT_HI;
            end
            PH_CNT_HI: begin
                count = {b, held_lo};
                loaded = '0;
                bit_acc = '0;
                nbits = 0;
                if (count == 16'd0) begin
                    width = '0;
                    phase = PH_PIXELS;
                end else begin
                    phase = PH_ENT_LO;
                end
            end
            PH_ENT_LO: begin
                held_lo = b;
                phase = PH_ENT_HI;
            end
            PH_ENT_HI: begin
                if (loaded < PALETTE_DEPTH) begin
                    colors[loaded[PAL_ADDR_W-1:0]] = {b, held_lo};
                end
                loaded = loaded + 16'd1;
                if (loaded >= count) begin
                    width = bits_for(count);
                    phase = PH_PIXELS;
                end else begin
                    phase = PH_ENT_LO;
                end
            end
            PH_PIXELS: begin
                if (width != '0) begin
                    mask = (32'd1 << width) - 32'd1;
                    bit_acc = bit_acc | (32'(b) << nbits);
                    nbits += 8;
                    while (nbits >= width && produced < 16) begin
                        emit_pixel(16'(bit_acc & mask));
                        produced += 2;
                        bit_acc = bit_acc >> width;
                        nbits -= width;
                    end
                    // leftover bits at the end form one zero-padded index
                    if (eos && nbits != 0 && produced < 16) begin
                        emit_pixel(16'(bit_acc & mask));
                        produced += 2;
                        bit_acc = '0;
                        nbits = 0;
                    end
                    bit_acc = bit_acc & 32'h007F_FFFF;
                end
            end
            default: begin
                phase = PH_CNT_LO;
            end
        endcase
        if (produced > 0) begin
            pixel_bytes_due[pixel_bytes_due.size() - 1].last = 1'b1;
        end
        if (eos) begin
            phase = PH_CNT_LO;
            loaded = '0;
            bit_acc = '0;
            nbits = 0;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            phase = PH_CNT_LO;
            count = '0;
            loaded = '0;
            held_lo = '0;
            width = '0;
            bit_acc = '0;
            nbits = 0;
            pixel_bytes_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (pixel_bytes_due.size() == 0) begin
                    flag_mismatch($sformatf("unexpected output byte %02h", m_pixel_byte));
                end else begin
                    due = pixel_bytes_due.pop_front();
                    if (m_pixel_byte !== due.value) begin
                        flag_mismatch($sformatf("pixel_byte %02h, want %02h",
                                                m_pixel_byte, due.value));
                    end
                    if (m_bad_index !== due.bad) begin
                        flag_mismatch($sformatf("bad_index %b, want %b",
                                                m_bad_index, due.bad));
                    end
                    if (m_run_last !== due.last) begin
                        flag_mismatch($sformatf("run_last %b, want %b",
                                                m_run_last, due.last));
                    end
                end
            end
            if (s_valid && s_ready) begin
                decode_stream_byte(s_stream_byte, s_end_of_stream);
            end
        end
        outstanding <= pixel_bytes_due.size();
    end

endmodule

// File: sim/palette_image_decoder_test.sv
// palette_image_decoder_test: stimulus and verdict for the palette image decoder
// depends on pid_pkg, the decoder RTL and palette_image_decoder_checker
`timescale 1ns / 1ps

module palette_image_decoder_test;
    import pid_pkg::*;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic [7:0] s_stream_byte = 8'h00;
    logic       s_end_of_stream = 1'b0;
    logic       m_ready = 1'b0;
    logic       s_ready;
    logic       m_valid;
    logic [7:0] m_pixel_byte;
    logic       m_bad_index;
    logic       m_run_last;

    int         mismatches;
    int         outstanding;
    int         send_idle_pct = 38;
    int         recv_stall_pct = 38;
    int         bytes_sent = 0;
    logic [7:0] index_bytes[$];

    palette_image_decoder dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_stream_byte   (s_stream_byte),
        .s_end_of_stream (s_end_of_stream),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_byte    (m_pixel_byte),
        .m_bad_index     (m_bad_index),
        .m_run_last      (m_run_last)
    );

    palette_image_decoder_checker decode_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_stream_byte   (s_stream_byte),
        .s_end_of_stream (s_end_of_stream),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_byte    (m_pixel_byte),
        .m_bad_index     (m_bad_index),
        .m_run_last      (m_run_last),
        .mismatches      (mismatches),
        .outstanding     (outstanding)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic put_byte(input logic [7:0] b, input logic eos);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_stream_byte <= b;
        s_end_of_stream <= eos;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
    endtask

    // header with random colors, then index_bytes; cut >= 0 ends the stream
    // early on that header byte
    task automatic send_stream(input int count, input int cut);
        int         n;
        logic [7:0] b;
        n = 2 + 2 * count;
        for (int i = 0; i < n; i++) begin
            if (i == 0) begin
                b = count[7:0];
            end else if (i == 1) begin
                b = count[15:8];
            end else begin
                b = 8'($urandom_range(0, 255));
            end
            put_byte(b, i == cut);
            if (i == cut) return;
        end
        for (int i = 0; i < index_bytes.size(); i++) begin
            put_byte(index_bytes[i], i == index_bytes.size() - 1);
        end
    endtask

    initial begin
        int count;
        int cut;
        int r;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero count: pixel bytes are swallowed
        index_bytes = '{8'hFF, 8'h00};
        send_stream(0, -1);
        // streams cut short inside the header
        send_stream(300, 0);
        send_stream(2, 1);
        send_stream(2, 3);
        // one entry, one-bit indices: a full byte of out-of-range indices
        index_bytes = '{8'hFF, 8'h00, 8'hA5};
        send_stream(1, -1);
        index_bytes = '{8'hE4, 8'h1B};
        send_stream(3, -1);
        // three-bit indices straddle bytes, last one zero padded
        index_bytes = '{8'hFF, 8'hFF};
        send_stream(5, -1);

        // a stretch with no idling on either side
        send_idle_pct = 0;
        recv_stall_pct = 0;
        index_bytes = '{8'h00, 8'h01, 8'hFF, 8'hFF, 8'h3C};
        send_stream(16, -1);
        index_bytes = '{8'hFF, 8'h80, 8'h07};
        send_stream(9, -1);

        send_idle_pct = 38;
        recv_stall_pct = 38;
        while (bytes_sent < 150) begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
                count = 0;
            end else if (r < 45) begin
                count = $urandom_range(1, 4);
            end else if (r < 85) begin
                count = $urandom_range(5, 8);
            end else begin
                count = $urandom_range(9, 20);
            end
            cut = -1;
            if ($urandom_range(0, 99) < 15) begin
                cut = $urandom_range(0, 1 + 2 * count);
            end
            index_bytes.delete();
            repeat ($urandom_range(1, 12)) index_bytes.push_back(8'($urandom_range(0, 255)));
            send_stream(count, cut);
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: files.f
design/pid_pkg.sv
design/pid_ram.sv
design/pid_ctrl.sv
design/pid_datapath.sv
design/palette_image_decoder.sv
design/pid_checker.sv
sim/palette_image_decoder_checker.sv
sim/palette_image_decoder_test.sv
